// ----- rtl/gsar_pkg.sv -----
// Shared types and constants for the greedy string art router.
// No dependencies.
package gsar_pkg;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_NAIL  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_WINDING_LIMIT = 2'd0,
    REG_LIGHT_MODE    = 2'd1,
    REG_COORD_OFFSET  = 2'd2,
    REG_NAIL_COUNT    = 2'd3
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MODK, ST_MODD, ST_CHECK, ST_RDA, ST_GETA, ST_CAND, ST_SETB,
    ST_WALK, ST_DRAIN, ST_DIVI, ST_DIV, ST_CMP, ST_DECIDE, ST_SETC, ST_FIN
  } state_e;

  localparam logic [7:0]  PIX_MAX        = 8'd255;
  localparam logic [15:0] LIMIT_RESET    = 16'd1000;
  localparam logic [7:0]  OFFSET_RESET   = 8'd1;
  localparam logic [8:0]  NCOUNT_RESET   = 9'd256;
  localparam int          CFG_DATA_W     = 16;

endpackage

// ----- rtl/gsar_in_if.sv -----
// Input item channel of the string art router: valid/ready plus payload.
// No dependencies.
interface gsar_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] pixel_value;
  logic [7:0] nail_slot;
  logic [7:0] nail_x;
  logic [7:0] nail_y;

  modport source (output valid, cmd, pixel_x, pixel_y, pixel_value, nail_slot, nail_x,
                  nail_y, input ready);
  modport sink (input valid, cmd, pixel_x, pixel_y, pixel_value, nail_slot, nail_x,
                nail_y, output ready);
endinterface

// ----- rtl/gsar_out_if.sv -----
// Result item channel of the string art router: valid/ready plus payload.
// No dependencies.
interface gsar_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] winding_number;
  logic [7:0]  from_nail;
  logic [7:0]  to_nail;
  logic        line_valid;
  logic        run_done;

  modport source (output valid, winding_number, from_nail, to_nail, line_valid, run_done,
                  input ready);
  modport sink (input valid, winding_number, from_nail, to_nail, line_valid, run_done,
                output ready);
endinterface

// ----- rtl/gsar_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsar_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/greedy_string_art_router_unit.sv -----
// Greedy string art router: loads a grey image and a nail table, then each step
// item picks the next nail by averaging a per-pixel score along Bresenham lines.
// Depends on gsar_pkg, gsar_in_if, gsar_out_if and gsar_ram.
//
// Pixel and nail load items are written into their RAMs when accepted. A step
// item walks every candidate line one pixel per cycle out of the image RAM (its
// single read port sets the pace), then goes per candidate through the candidate
// check, the nail read, the read drain, the divide set-up, a shift-subtract divide
// for the average and the compare. Nails inside the window are only stepped past
// in the candidate check. A short prologue first reduces the nail indices modulo
// the count, and after the search the chosen line is overwritten, again one pixel
// per cycle. One item is worked at a time; the finished result sits in an output
// register and the block goes back to idle as soon as the result is loaded there.
// No clearing pass is done: the image and the nail table must be written before
// they are used.
module greedy_string_art_router_unit #(
  parameter int IMAGE_SIDE   = 256,
  parameter int MAX_NAILS    = 256,
  parameter int EXCLUDE_HALF = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [gsar_pkg::CFG_DATA_W-1:0] cfg_data_i,
  gsar_in_if.sink                       in_i,
  gsar_out_if.source                    out_o
);

  localparam int CW  = $clog2(IMAGE_SIDE);                 // coordinate bits
  localparam int IA  = $clog2(IMAGE_SIDE * IMAGE_SIDE);    // image address bits
  localparam int NA  = $clog2(MAX_NAILS);                  // nail address bits
  localparam int NW  = $clog2(MAX_NAILS + 1);              // nail count bits
  localparam int DW  = $clog2(MAX_NAILS + EXCLUDE_HALF + 2);
  localparam int NCW = $clog2(IMAGE_SIDE + 1);             // pixel count bits
  localparam int SW  = NCW + 8;                            // score sum bits
  localparam int EW  = CW + 3;                             // Bresenham error bits
  localparam int WIN = 2 * EXCLUDE_HALF;

  // configuration
  logic [15:0] limit_q;
  logic        light_q;
  logic [7:0]  off_q;
  logic [8:0]  ncount_q;

  // architectural state
  gsar_pkg::state_e state_q, state_d;
  logic [NW-1:0] cur_q;
  logic [15:0]   wc_q;
  logic          stopped_q;
  logic          out_valid_q;

  // step datapath
  logic [NW-1:0]         k_q, j_q, bestj_q;
  logic [DW-1:0]         d_q;
  logic [7:0]            best_q, quo_q;
  logic [CW-1:0]         xa_q, ya_q, x_q, y_q, x1_q, y1_q;
  logic signed [EW-1:0]  dx_q, dy_q, err_q;
  logic                  sx_q, sy_q, clr_q, rd_pend_q;
  logic [SW-1:0]         sum_q, rem_q;
  logic [NCW-1:0]        n_q;
  logic [2:0]            bit_q;
  logic [15:0]           res_wn_q;
  logic [7:0]            res_from_q, res_to_q;
  logic                  res_lv_q, res_done_q;

  logic [NW-1:0] cnt_eff;
  logic          in_acc;
  logic          at_end;
  logic          img_we, nail_we;
  logic [IA-1:0] img_waddr, img_raddr;
  logic [7:0]    img_wdata, img_rdata;
  logic [NA-1:0] nail_raddr;
  logic [15:0]   nail_rdata;
  logic [CW-1:0] bx, by;
  logic signed [EW-1:0] e2;
  logic [SW:0]   trial;
  logic [DW-1:0] d_inc;
  logic          out_load;

  function automatic logic [CW-1:0] clampc(input logic [8:0] v);
    if (32'(v) > IMAGE_SIDE - 1) return CW'(IMAGE_SIDE - 1);
    else return CW'(v);
  endfunction

  function automatic logic [IA-1:0] pix_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return IA'(IA'(x) * IA'(IMAGE_SIDE) + IA'(y));
  endfunction

  // nail count with the out-of-range values pulled in
  always_comb begin
    if (ncount_q == 9'd0) cnt_eff = NW'(1);
    else if (32'(ncount_q) > MAX_NAILS) cnt_eff = NW'(MAX_NAILS);
    else cnt_eff = NW'(ncount_q);
  end

  assign in_i.ready = (state_q == gsar_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign at_end     = (x_q == x1_q) && (y_q == y1_q);
  assign e2         = err_q <<< 1;
  assign trial      = (SW+1)'(n_q) << bit_q;
  assign d_inc      = ((d_q + DW'(1)) == DW'(cnt_eff)) ? '0 : d_q + DW'(1);
  assign bx = clampc(9'(nail_rdata[15:8]) + 9'(off_q));
  assign by = clampc(9'(nail_rdata[7:0]) + 9'(off_q));
  assign out_load = (state_q == gsar_pkg::ST_FIN) && (!out_valid_q || out_o.ready);

  // memory ports
  always_comb begin
    img_we     = 1'b0;
    img_waddr  = pix_addr(x_q, y_q);
    img_wdata  = light_q ? 8'd0 : gsar_pkg::PIX_MAX;
    img_raddr  = pix_addr(x_q, y_q);
    nail_we    = 1'b0;
    nail_raddr = NA'(j_q);
    if (in_acc && in_i.cmd == gsar_pkg::CMD_PIXEL &&
        32'(in_i.pixel_x) < IMAGE_SIDE && 32'(in_i.pixel_y) < IMAGE_SIDE) begin
      img_we    = 1'b1;
      img_waddr = IA'(IA'(in_i.pixel_x) * IA'(IMAGE_SIDE) + IA'(in_i.pixel_y));
      img_wdata = in_i.pixel_value;
    end
    if (in_acc && in_i.cmd == gsar_pkg::CMD_NAIL && 32'(in_i.nail_slot) < MAX_NAILS) begin
      nail_we = 1'b1;
    end
    if (state_q == gsar_pkg::ST_WALK && clr_q) img_we = 1'b1;
    if (state_q == gsar_pkg::ST_RDA) nail_raddr = NA'(k_q);
    if (state_q == gsar_pkg::ST_DECIDE) nail_raddr = NA'(bestj_q);
  end

  gsar_ram #(.Width(8), .Depth(IMAGE_SIDE * IMAGE_SIDE)) u_image (
    .clk_i, .we_i(img_we), .waddr_i(img_waddr), .wdata_i(img_wdata),
    .raddr_i(img_raddr), .rdata_o(img_rdata)
  );

  gsar_ram #(.Width(16), .Depth(MAX_NAILS)) u_nails (
    .clk_i, .we_i(nail_we), .waddr_i(NA'(in_i.nail_slot)),
    .wdata_i({in_i.nail_x, in_i.nail_y}), .raddr_i(nail_raddr), .rdata_o(nail_rdata)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gsar_pkg::ST_IDLE:
        if (in_acc && in_i.cmd == gsar_pkg::CMD_STEP) state_d = gsar_pkg::ST_MODK;
      gsar_pkg::ST_MODK:   if (k_q < cnt_eff) state_d = gsar_pkg::ST_MODD;
      gsar_pkg::ST_MODD:   if (d_q < DW'(cnt_eff)) state_d = gsar_pkg::ST_CHECK;
      gsar_pkg::ST_CHECK:
        state_d = (stopped_q || wc_q >= limit_q) ? gsar_pkg::ST_FIN : gsar_pkg::ST_RDA;
      gsar_pkg::ST_RDA:    state_d = gsar_pkg::ST_GETA;
      gsar_pkg::ST_GETA:   state_d = gsar_pkg::ST_CAND;
      gsar_pkg::ST_CAND:
        if (j_q == cnt_eff) state_d = gsar_pkg::ST_DECIDE;
        else if (32'(d_q) >= WIN) state_d = gsar_pkg::ST_SETB;
      gsar_pkg::ST_SETB:   state_d = gsar_pkg::ST_WALK;
      gsar_pkg::ST_WALK:
        if (at_end) state_d = clr_q ? gsar_pkg::ST_FIN : gsar_pkg::ST_DRAIN;
      gsar_pkg::ST_DRAIN:  state_d = gsar_pkg::ST_DIVI;
      gsar_pkg::ST_DIVI:   state_d = gsar_pkg::ST_DIV;
      gsar_pkg::ST_DIV:    if (bit_q == 3'd0) state_d = gsar_pkg::ST_CMP;
      gsar_pkg::ST_CMP:    state_d = gsar_pkg::ST_CAND;
      gsar_pkg::ST_DECIDE:
        state_d = (best_q == 8'd0) ? gsar_pkg::ST_FIN : gsar_pkg::ST_SETC;
      gsar_pkg::ST_SETC:   state_d = gsar_pkg::ST_WALK;
      gsar_pkg::ST_FIN:    if (out_load) state_d = gsar_pkg::ST_IDLE;
      default:             state_d = gsar_pkg::ST_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gsar_pkg::ST_IDLE;
      cur_q       <= '0;
      wc_q        <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= gsar_pkg::LIMIT_RESET;
      light_q     <= 1'b0;
      off_q       <= gsar_pkg::OFFSET_RESET;
      ncount_q    <= gsar_pkg::NCOUNT_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (gsar_pkg::reg_idx_e'(cfg_idx_i))
          gsar_pkg::REG_WINDING_LIMIT: limit_q  <= cfg_data_i;
          gsar_pkg::REG_LIGHT_MODE:    light_q  <= cfg_data_i[0];
          gsar_pkg::REG_COORD_OFFSET:  off_q    <= cfg_data_i[7:0];
          gsar_pkg::REG_NAIL_COUNT:    ncount_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (state_q == gsar_pkg::ST_DECIDE && best_q == 8'd0) stopped_q <= 1'b1;
      if (state_q == gsar_pkg::ST_WALK && clr_q && at_end) begin
        cur_q <= bestj_q;
        wc_q  <= wc_q + 16'd1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // step datapath
  always_ff @(posedge clk_i) begin
    // image read data lands in the cycle after each scoring walk cycle
    rd_pend_q <= (state_q == gsar_pkg::ST_WALK) && !clr_q;
    if (rd_pend_q) begin
      sum_q <= sum_q + SW'(light_q ? img_rdata : gsar_pkg::PIX_MAX - img_rdata);
    end
    unique case (state_q)
      gsar_pkg::ST_IDLE: k_q <= cur_q;
      gsar_pkg::ST_MODK:
        if (k_q >= cnt_eff) k_q <= k_q - cnt_eff;
        else d_q <= DW'(DW'(cnt_eff) + DW'(EXCLUDE_HALF) - DW'(k_q));
      gsar_pkg::ST_MODD:
        if (d_q >= DW'(cnt_eff)) d_q <= d_q - DW'(cnt_eff);
      gsar_pkg::ST_CHECK: begin
        res_wn_q   <= wc_q;
        res_from_q <= 8'(k_q);
        res_to_q   <= 8'd0;
        res_lv_q   <= 1'b0;
        res_done_q <= 1'b1;
      end
      gsar_pkg::ST_GETA: begin
        xa_q    <= bx;
        ya_q    <= by;
        j_q     <= '0;
        best_q  <= 8'd0;
        bestj_q <= '0;
      end
      gsar_pkg::ST_CAND:
        if (j_q != cnt_eff && 32'(d_q) < WIN) begin
          j_q <= j_q + NW'(1);
          d_q <= d_inc;
        end
      gsar_pkg::ST_SETB, gsar_pkg::ST_SETC: begin
        x_q   <= xa_q;
        y_q   <= ya_q;
        x1_q  <= bx;
        y1_q  <= by;
        dx_q  <= (bx > xa_q) ? EW'(bx - xa_q) : EW'(xa_q - bx);
        dy_q  <= (by > ya_q) ? EW'(by - ya_q) : EW'(ya_q - by);
        err_q <= ((bx > xa_q) ? EW'(bx - xa_q) : EW'(xa_q - bx)) -
                 ((by > ya_q) ? EW'(by - ya_q) : EW'(ya_q - by));
        sx_q  <= xa_q < bx;
        sy_q  <= ya_q < by;
        sum_q <= '0;
        n_q   <= '0;
        clr_q <= (state_q == gsar_pkg::ST_SETC);
      end
      gsar_pkg::ST_WALK: begin
        n_q <= n_q + NCW'(1);
        if (!at_end) begin
          err_q <= err_q - ((e2 > -dy_q) ? dy_q : EW'(0)) + ((e2 < dx_q) ? dx_q : EW'(0));
          if (e2 > -dy_q) x_q <= sx_q ? x_q + CW'(1) : x_q - CW'(1);
          if (e2 < dx_q)  y_q <= sy_q ? y_q + CW'(1) : y_q - CW'(1);
        end else if (clr_q) begin
          res_to_q   <= 8'(bestj_q);
          res_lv_q   <= 1'b1;
          res_done_q <= (wc_q + 16'd1) >= limit_q;
        end
      end
      gsar_pkg::ST_DRAIN: ;
      gsar_pkg::ST_DIVI: begin
        rem_q <= sum_q;
        quo_q <= 8'd0;
        bit_q <= 3'd7;
      end
      gsar_pkg::ST_DIV: begin
        // restoring divide, one quotient bit per cycle; average is below 256
        if ((SW+1)'(rem_q) >= trial) begin
          rem_q        <= SW'((SW+1)'(rem_q) - trial);
          quo_q[bit_q] <= 1'b1;
        end
        bit_q <= bit_q - 3'd1;
      end
      gsar_pkg::ST_CMP: begin
        if (quo_q > best_q) begin
          best_q  <= quo_q;
          bestj_q <= j_q;
        end
        j_q <= j_q + NW'(1);
        d_q <= d_inc;
      end
      gsar_pkg::ST_RDA, gsar_pkg::ST_DECIDE, gsar_pkg::ST_FIN: ;
      default: ;
    endcase
    if (out_load) begin
      out_o.winding_number <= res_wn_q;
      out_o.from_nail      <= res_from_q;
      out_o.to_nail        <= res_to_q;
      out_o.line_valid     <= res_lv_q;
      out_o.run_done       <= res_done_q;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule
